/* rtl/core/pgf_pkg.sv */
`default_nettype none

package pgf_pkg;

	// field and register widths
	localparam int unsigned POS_W  = 32;
	localparam int unsigned MASS_W = 32;
	localparam int unsigned CFG_W  = 32;
	localparam int unsigned EPS_W  = 16;
	localparam int unsigned IDX_W  = 2;

	// internal widths
	localparam int unsigned SQ_W     = 64;            // square sum, Q32.32
	localparam int unsigned ROOT_W   = 32;            // distance, Q16.16
	localparam int unsigned SQ_REM_W = ROOT_W + 2;    // sqrt partial remainder
	localparam int unsigned NUM_W    = 96;            // G*ma*mb
	localparam int unsigned FRC_W    = 32;            // force magnitude / quotients
	localparam int unsigned PROD_W   = 2 * FRC_W;

	// pipeline depth: front stages, sqrt/divide chain, middle stages, component chain, output
	localparam int unsigned FRONT_STAGES = 4;
	localparam int unsigned MID_STAGES   = 3;
	localparam int unsigned LATENCY      = FRONT_STAGES + ROOT_W + MID_STAGES + FRC_W + 1;

	localparam logic [CFG_W-1:0] GRAVITY_RESET = 32'd65536;
	localparam logic [CFG_W-1:0] CUTOFF_RESET  = 32'd6553600;
	localparam logic [EPS_W-1:0] EPSILON_RESET = 16'd1;

	typedef enum logic [IDX_W-1:0] {
		REG_GRAVITY = 2'd0,
		REG_CUTOFF  = 2'd1,
		REG_EPSILON = 2'd2
	} reg_idx_t;

	// sideband carried along the sqrt chain
	typedef struct packed {
		logic              skip;
		logic              neg_x;
		logic              neg_y;
		logic [POS_W-1:0]  mag_x;
		logic [POS_W-1:0]  mag_y;
	} sqrt_tag_t;

	// sideband carried along each component lane
	typedef struct packed {
		logic skip;
		logic big;
		logic neg;
	} lane_tag_t;

endpackage

`default_nettype wire

/* rtl/core/pgf_sqrt_cell.sv */
`default_nettype none

// one radix-2 restoring square root step, registered
module pgf_sqrt_cell import pgf_pkg::*; #(
	parameter int unsigned TAG_W = 1
) (
	input  logic                clk,
	input  logic [SQ_W-1:0]     rad_i,
	input  logic [SQ_REM_W-1:0] rem_i,
	input  logic [ROOT_W-1:0]   root_i,
	input  logic [TAG_W-1:0]    tag_i,
	output logic [SQ_W-1:0]     rad_o,
	output logic [SQ_REM_W-1:0] rem_o,
	output logic [ROOT_W-1:0]   root_o,
	output logic [TAG_W-1:0]    tag_o
);

	logic [SQ_REM_W+1:0] shifted;
	logic [SQ_REM_W+1:0] trial;
	logic [SQ_REM_W+1:0] diff;
	logic                ge;

	always_comb begin
		shifted = {rem_i, rad_i[SQ_W-1 -: 2]};
		trial   = {{(SQ_REM_W - ROOT_W){1'b0}}, root_i, 2'b01};
		diff    = shifted - trial;
		ge      = (shifted >= trial);
	end

	always_ff @(posedge clk) begin
		rad_o  <= {rad_i[SQ_W-3:0], 2'b00};
		rem_o  <= ge ? diff[SQ_REM_W-1:0] : shifted[SQ_REM_W-1:0];
		root_o <= {root_i[ROOT_W-2:0], ge};
		tag_o  <= tag_i;
	end

endmodule

`default_nettype wire

/* rtl/core/pgf_div_cell.sv */
`default_nettype none

// one restoring division step, registered; quotient bits shift in as numerator bits shift out
module pgf_div_cell #(
	parameter int unsigned DW    = 64,
	parameter int unsigned NW    = 32,
	parameter int unsigned TAG_W = 1
) (
	input  logic             clk,
	input  logic [DW-1:0]    div_i,
	input  logic [DW-1:0]    rem_i,
	input  logic [NW-1:0]    nq_i,
	input  logic [TAG_W-1:0] tag_i,
	output logic [DW-1:0]    div_o,
	output logic [DW-1:0]    rem_o,
	output logic [NW-1:0]    nq_o,
	output logic [TAG_W-1:0] tag_o
);

	logic [DW:0] t;
	logic [DW:0] diff;
	logic        ge;

	always_comb begin
		t    = {rem_i, nq_i[NW-1]};
		diff = t - {1'b0, div_i};
		ge   = (t >= {1'b0, div_i});
	end

	always_ff @(posedge clk) begin
		div_o <= div_i;
		rem_o <= ge ? diff[DW-1:0] : t[DW-1:0];
		nq_o  <= {nq_i[NW-2:0], ge};
		tag_o <= tag_i;
	end

endmodule

`default_nettype wire

/* rtl/core/pairwise_gravity_force.sv */
`default_nettype none

// Pairwise 2-D gravity force.
// Input: a pair transfer is taken on a rising edge with start high and busy low.
//   busy is always low: the pipeline takes a new pair every cycle.
// Output: done pulses for one cycle with force_x, force_y, force_applied valid;
//   the receiver cannot stall, so results simply flow out.
// Pipeline: from the accepting edge the result passes through
//   4 front stages, 32 sqrt/divide cells, 3 middle stages, 32 component
//   divide cells and 1 output register. Throughput: one pair per cycle.
//   The depth is set by the two 32-cell chains: one root bit and one quotient
//   bit per cell.
// Config: wr_en/wr_index/wr_data write G, cutoff, epsilon; write while idle.
//   Index 3 is ignored.
// Reset: arst_n clears registers to G = 1.0, cutoff = 100.0, epsilon = 1 lsb,
//   and drops every pair in flight.
module pairwise_gravity_force import pgf_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic signed [POS_W-1:0]  pos_a_x,
	input  logic signed [POS_W-1:0]  pos_a_y,
	input  logic signed [POS_W-1:0]  pos_b_x,
	input  logic signed [POS_W-1:0]  pos_b_y,
	input  logic [MASS_W-1:0]        mass_a,
	input  logic [MASS_W-1:0]        mass_b,
	input  logic                     infinite_a,
	input  logic                     infinite_b,
	input  logic                     wr_en,
	input  logic [IDX_W-1:0]         wr_index,
	input  logic [CFG_W-1:0]         wr_data,
	output logic                     done,
	output logic signed [FRC_W-1:0]  force_x,
	output logic signed [FRC_W-1:0]  force_y,
	output logic                     force_applied
);

	localparam int unsigned STAG_W = $bits(sqrt_tag_t);
	localparam int unsigned LTAG_W = $bits(lane_tag_t);

	// ---------------- configuration registers ----------------
	logic [CFG_W-1:0] gravity_q;
	logic [CFG_W-1:0] cutoff_q;
	logic [EPS_W-1:0] eps_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gravity_q <= GRAVITY_RESET;
			cutoff_q  <= CUTOFF_RESET;
			eps_q     <= EPSILON_RESET;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_GRAVITY: gravity_q <= wr_data;
				REG_CUTOFF:  cutoff_q  <= wr_data;
				REG_EPSILON: eps_q     <= wr_data[EPS_W-1:0];
				default: ;
			endcase
		end
	end

	logic [FRC_W-1:0] eps_ext;
	assign eps_ext = {{(FRC_W - EPS_W){1'b0}}, eps_q};

	// ---------------- handshake / valid tracking ----------------
	logic                accept;
	logic [LATENCY-1:0]  vld_q;

	assign busy   = 1'b0;
	assign accept = start & ~busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[LATENCY-2:0], accept};
		end
	end

	assign done = vld_q[LATENCY-1];

	// ---------------- s1: deltas, G*ma ----------------
	// 33-bit exact deltas; magnitudes fit in 32 bits
	logic [POS_W:0] dx, dy, ndx, ndy;

	always_comb begin
		dx  = {pos_b_x[POS_W-1], pos_b_x} - {pos_a_x[POS_W-1], pos_a_x};
		dy  = {pos_b_y[POS_W-1], pos_b_y} - {pos_a_y[POS_W-1], pos_a_y};
		ndx = ~dx + 1'b1;
		ndy = ~dy + 1'b1;
	end

	logic [POS_W-1:0]  mag_x_s1, mag_y_s1;
	logic              neg_x_s1, neg_y_s1, inf_s1;
	logic [PROD_W-1:0] p_s1;
	logic [MASS_W-1:0] mass_b_s1;

	always_ff @(posedge clk) begin
		neg_x_s1  <= dx[POS_W];
		neg_y_s1  <= dy[POS_W];
		mag_x_s1  <= dx[POS_W] ? ndx[POS_W-1:0] : dx[POS_W-1:0];
		mag_y_s1  <= dy[POS_W] ? ndy[POS_W-1:0] : dy[POS_W-1:0];
		inf_s1    <= infinite_a & infinite_b;
		p_s1      <= {{(PROD_W - CFG_W){1'b0}}, gravity_q} *
		             {{(PROD_W - MASS_W){1'b0}}, mass_a};
		mass_b_s1 <= mass_b;
	end

	// ---------------- s2: squares, partial products of G*ma*mb ----------------
	logic [SQ_W-1:0]   sxx_s2, syy_s2;
	logic [PROD_W-1:0] lo_s2, hi_s2;
	logic [POS_W-1:0]  mag_x_s2, mag_y_s2;
	logic              neg_x_s2, neg_y_s2, inf_s2;

	always_ff @(posedge clk) begin
		sxx_s2   <= {{(SQ_W - POS_W){1'b0}}, mag_x_s1} * {{(SQ_W - POS_W){1'b0}}, mag_x_s1};
		syy_s2   <= {{(SQ_W - POS_W){1'b0}}, mag_y_s1} * {{(SQ_W - POS_W){1'b0}}, mag_y_s1};
		lo_s2    <= {{(PROD_W - 32){1'b0}}, p_s1[31:0]} *
		            {{(PROD_W - MASS_W){1'b0}}, mass_b_s1};
		hi_s2    <= {{(PROD_W - 32){1'b0}}, p_s1[PROD_W-1:32]} *
		            {{(PROD_W - MASS_W){1'b0}}, mass_b_s1};
		mag_x_s2 <= mag_x_s1;
		mag_y_s2 <= mag_y_s1;
		neg_x_s2 <= neg_x_s1;
		neg_y_s2 <= neg_y_s1;
		inf_s2   <= inf_s1;
	end

	// ---------------- s3: square sum, full numerator ----------------
	logic [SQ_W:0]     sq_sum;
	logic [SQ_W-1:0]   sq_s3;
	logic [NUM_W-1:0]  num_s3;
	sqrt_tag_t         tag_s3;

	assign sq_sum = {1'b0, sxx_s2} + {1'b0, syy_s2};

	always_ff @(posedge clk) begin
		sq_s3        <= sq_sum[SQ_W-1:0];
		num_s3       <= {{(NUM_W - PROD_W){1'b0}}, lo_s2} +
		                {hi_s2, {(NUM_W - PROD_W){1'b0}}};
		// square sum past 64 bits is beyond any cutoff
		tag_s3.skip  <= inf_s2 | sq_sum[SQ_W];
		tag_s3.neg_x <= neg_x_s2;
		tag_s3.neg_y <= neg_y_s2;
		tag_s3.mag_x <= mag_x_s2;
		tag_s3.mag_y <= mag_y_s2;
	end

	// ---------------- s4: force overflow check ----------------
	// quotient >= 2^32 exactly when the upper 64 numerator bits reach the divisor
	logic [SQ_W-1:0]  sq_s4;
	logic [NUM_W-1:0] num_s4;
	logic             big_s4;
	sqrt_tag_t        tag_s4;

	always_ff @(posedge clk) begin
		sq_s4  <= sq_s3;
		num_s4 <= num_s3;
		big_s4 <= (num_s3[NUM_W-1:FRC_W] >= sq_s3);
		tag_s4 <= tag_s3;
	end

	// ---------------- sqrt chain and force divide chain, side by side ----------------
	logic [SQ_W-1:0]     rad   [0:ROOT_W];
	logic [SQ_REM_W-1:0] srem  [0:ROOT_W];
	logic [ROOT_W-1:0]   root  [0:ROOT_W];
	logic [STAG_W-1:0]   stag  [0:ROOT_W];
	logic [SQ_W-1:0]     ddiv  [0:ROOT_W];
	logic [SQ_W-1:0]     drem  [0:ROOT_W];
	logic [FRC_W-1:0]    dnq   [0:ROOT_W];
	logic                dbig  [0:ROOT_W];

	assign rad[0]  = sq_s4;
	assign srem[0] = '0;
	assign root[0] = '0;
	assign stag[0] = tag_s4;
	assign ddiv[0] = sq_s4;
	assign drem[0] = num_s4[NUM_W-1:FRC_W];
	assign dnq[0]  = num_s4[FRC_W-1:0];
	assign dbig[0] = big_s4;

	for (genvar i = 0; i < ROOT_W; i++) begin : g_chain
		pgf_sqrt_cell #(
			.TAG_W(STAG_W)
		) u_sqrt (
			.clk   (clk),
			.rad_i (rad[i]),
			.rem_i (srem[i]),
			.root_i(root[i]),
			.tag_i (stag[i]),
			.rad_o (rad[i+1]),
			.rem_o (srem[i+1]),
			.root_o(root[i+1]),
			.tag_o (stag[i+1])
		);

		pgf_div_cell #(
			.DW   (SQ_W),
			.NW   (FRC_W),
			.TAG_W(1)
		) u_fdiv (
			.clk  (clk),
			.div_i(ddiv[i]),
			.rem_i(drem[i]),
			.nq_i (dnq[i]),
			.tag_i(dbig[i]),
			.div_o(ddiv[i+1]),
			.rem_o(drem[i+1]),
			.nq_o (dnq[i+1]),
			.tag_o(dbig[i+1])
		);
	end

	// ---------------- s5: distance checks, saturated force ----------------
	sqrt_tag_t        tag_end;
	logic [ROOT_W-1:0] d_s5;
	logic [FRC_W-1:0]  f_s5;
	logic              skip_s5, neg_x_s5, neg_y_s5;
	logic [POS_W-1:0]  mag_x_s5, mag_y_s5;

	assign tag_end = stag[ROOT_W];

	always_ff @(posedge clk) begin
		d_s5     <= root[ROOT_W];
		f_s5     <= dbig[ROOT_W] ? '1 : dnq[ROOT_W];
		// too far, or coincident
		skip_s5  <= tag_end.skip | (root[ROOT_W] > cutoff_q) | (root[ROOT_W] <= eps_ext);
		neg_x_s5 <= tag_end.neg_x;
		neg_y_s5 <= tag_end.neg_y;
		mag_x_s5 <= tag_end.mag_x;
		mag_y_s5 <= tag_end.mag_y;
	end

	// ---------------- s6: F*|dx|, F*|dy| ----------------
	logic [PROD_W-1:0] px_s6, py_s6;
	logic [ROOT_W-1:0] d_s6;
	logic              skip_s6, neg_x_s6, neg_y_s6;

	always_ff @(posedge clk) begin
		px_s6    <= {{(PROD_W - FRC_W){1'b0}}, f_s5} * {{(PROD_W - POS_W){1'b0}}, mag_x_s5};
		py_s6    <= {{(PROD_W - FRC_W){1'b0}}, f_s5} * {{(PROD_W - POS_W){1'b0}}, mag_y_s5};
		d_s6     <= d_s5;
		// negligible force
		skip_s6  <= skip_s5 | (f_s5 <= eps_ext);
		neg_x_s6 <= neg_x_s5;
		neg_y_s6 <= neg_y_s5;
	end

	// ---------------- s7: component overflow check ----------------
	logic [PROD_W-1:0] px_s7, py_s7;
	logic [ROOT_W-1:0] d_s7;
	lane_tag_t         tx_s7, ty_s7;

	always_ff @(posedge clk) begin
		px_s7      <= px_s6;
		py_s7      <= py_s6;
		d_s7       <= d_s6;
		tx_s7.skip <= skip_s6;
		tx_s7.big  <= (px_s6[PROD_W-1:FRC_W] >= d_s6);
		tx_s7.neg  <= neg_x_s6;
		ty_s7.skip <= skip_s6;
		ty_s7.big  <= (py_s6[PROD_W-1:FRC_W] >= d_s6);
		ty_s7.neg  <= neg_y_s6;
	end

	// ---------------- component divide lanes ----------------
	logic [ROOT_W-1:0] xdiv [0:FRC_W];
	logic [ROOT_W-1:0] xrem [0:FRC_W];
	logic [FRC_W-1:0]  xnq  [0:FRC_W];
	logic [LTAG_W-1:0] xtag [0:FRC_W];
	logic [ROOT_W-1:0] ydiv [0:FRC_W];
	logic [ROOT_W-1:0] yrem [0:FRC_W];
	logic [FRC_W-1:0]  ynq  [0:FRC_W];
	logic [LTAG_W-1:0] ytag [0:FRC_W];

	assign xdiv[0] = d_s7;
	assign xrem[0] = px_s7[PROD_W-1:FRC_W];
	assign xnq[0]  = px_s7[FRC_W-1:0];
	assign xtag[0] = tx_s7;
	assign ydiv[0] = d_s7;
	assign yrem[0] = py_s7[PROD_W-1:FRC_W];
	assign ynq[0]  = py_s7[FRC_W-1:0];
	assign ytag[0] = ty_s7;

	for (genvar j = 0; j < FRC_W; j++) begin : g_lane
		pgf_div_cell #(
			.DW   (ROOT_W),
			.NW   (FRC_W),
			.TAG_W(LTAG_W)
		) u_xdiv (
			.clk  (clk),
			.div_i(xdiv[j]),
			.rem_i(xrem[j]),
			.nq_i (xnq[j]),
			.tag_i(xtag[j]),
			.div_o(xdiv[j+1]),
			.rem_o(xrem[j+1]),
			.nq_o (xnq[j+1]),
			.tag_o(xtag[j+1])
		);

		pgf_div_cell #(
			.DW   (ROOT_W),
			.NW   (FRC_W),
			.TAG_W(LTAG_W)
		) u_ydiv (
			.clk  (clk),
			.div_i(ydiv[j]),
			.rem_i(yrem[j]),
			.nq_i (ynq[j]),
			.tag_i(ytag[j]),
			.div_o(ydiv[j+1]),
			.rem_o(yrem[j+1]),
			.nq_o (ynq[j+1]),
			.tag_o(ytag[j+1])
		);
	end

	// ---------------- output register ----------------
	// signed saturation: positive clamps at 2^31-1, negative at -2^31
	function automatic logic [FRC_W-1:0] sat_comp(
		input logic [FRC_W-1:0] v,
		input logic             big,
		input logic             neg
	);
		logic [FRC_W-1:0] lim;
		logic [FRC_W-1:0] res;
		lim = {1'b1, {(FRC_W - 1){1'b0}}};
		if (neg) begin
			res = (big || (v > lim)) ? lim : (~v + 1'b1);
		end else begin
			res = (big || v[FRC_W-1]) ? (lim - 1'b1) : v;
		end
		return res;
	endfunction

	lane_tag_t        tx_end, ty_end;
	logic             skip_end;
	logic [FRC_W-1:0] force_x_q, force_y_q;
	logic             applied_q;

	assign tx_end   = xtag[FRC_W];
	assign ty_end   = ytag[FRC_W];
	assign skip_end = tx_end.skip | ty_end.skip;

	always_ff @(posedge clk) begin
		force_x_q <= skip_end ? '0 : sat_comp(xnq[FRC_W], tx_end.big, tx_end.neg);
		force_y_q <= skip_end ? '0 : sat_comp(ynq[FRC_W], ty_end.big, ty_end.neg);
		applied_q <= ~skip_end;
	end

	assign force_x       = force_x_q;
	assign force_y       = force_y_q;
	assign force_applied = applied_q;

	// ---------------- assertions ----------------
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LATENCY done)
		else $error("accepted pair did not produce a result at fixed latency");

	a_both_inf: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && infinite_a && infinite_b) |-> ##LATENCY (done && !force_applied))
		else $error("pair of infinite masses produced a force");

endmodule

`default_nettype wire

/* verif/tb_pairwise_gravity_force.sv */
module tb_pairwise_gravity_force;
	import pgf_pkg::*;

	// unused register slot; a write there must change nothing
	localparam logic [IDX_W-1:0] REG_SPARE = 2'd3;
	localparam int unsigned STALL_LIMIT = 2000;

	typedef struct packed {
		logic signed [FRC_W-1:0] fx;
		logic signed [FRC_W-1:0] fy;
		logic                    applied;
	} force_t;

	// one pair of bodies plus, for rows where it is obvious, the force we expect
	typedef struct packed {
		logic [POS_W-1:0]  ax, ay, bx, by;
		logic [MASS_W-1:0] ma, mb;
		logic              inf_a, inf_b;
		logic              known;
		force_t            want;
	} pair_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic signed [POS_W-1:0] pos_a_x = '0, pos_a_y = '0, pos_b_x = '0, pos_b_y = '0;
	logic [MASS_W-1:0] mass_a = '0, mass_b = '0;
	logic infinite_a = 1'b0, infinite_b = 1'b0;
	logic wr_en = 1'b0;
	logic [IDX_W-1:0] wr_index = REG_GRAVITY;
	logic [CFG_W-1:0] wr_data = '0;
	logic done;
	logic signed [FRC_W-1:0] force_x, force_y;
	logic force_applied;

	pairwise_gravity_force dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.pos_a_x(pos_a_x), .pos_a_y(pos_a_y), .pos_b_x(pos_b_x), .pos_b_y(pos_b_y),
		.mass_a(mass_a), .mass_b(mass_b), .infinite_a(infinite_a), .infinite_b(infinite_b),
		.wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
		.done(done), .force_x(force_x), .force_y(force_y), .force_applied(force_applied)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// mirror of the register file
	logic [CFG_W-1:0] g_const = GRAVITY_RESET;
	logic [CFG_W-1:0] cutoff = CUTOFF_RESET;
	logic [EPS_W-1:0] eps = EPSILON_RESET;

	force_t pending_forces[$];
	int unsigned mismatches = 0;
	int unsigned stall_cycles = 0;
	logic burst_mode = 1'b0;

	function automatic logic [31:0] floor_root(logic [63:0] n);
		logic [63:0] r, b;
		r = '0;
		b = 64'd1 << 62;
		while (b > n) b = b >> 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n = n - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r[31:0];
	endfunction

	// sign(delta) * floor(f*|delta|/d), clamped to the signed 32-bit range
	function automatic logic [31:0] axis_force(logic [31:0] f, logic [32:0] delta,
			logic [31:0] d);
		logic [32:0] mag;
		logic [64:0] v;
		mag = delta[32] ? -delta : delta;
		v = ({33'd0, f} * {32'd0, mag}) / {33'd0, d};
		if (delta[32]) begin
			if (v > 65'h80000000) v = 65'h80000000;
			return -v[31:0];
		end
		if (v > 65'h7FFFFFFF) v = 65'h7FFFFFFF;
		return v[31:0];
	endfunction

	function automatic force_t gravity_on_a(pair_row_t p);
		force_t r;
		logic [32:0] dx, dy, mx, my;
		logic [64:0] sq;
		logic [31:0] d, f;
		logic [95:0] num, q;
		r = '0;
		dx = {p.bx[31], p.bx} - {p.ax[31], p.ax};
		dy = {p.by[31], p.by} - {p.ay[31], p.ay};
		mx = dx[32] ? -dx : dx;
		my = dy[32] ? -dy : dy;
		sq = {32'd0, mx} * {32'd0, mx} + {32'd0, my} * {32'd0, my};
		if (p.inf_a && p.inf_b) return r;
		if (sq[64]) return r;                    // beyond any cutoff
		d = floor_root(sq[63:0]);
		if (d > cutoff || d <= {16'd0, eps}) return r;
		num = {64'd0, g_const} * {64'd0, p.ma} * {64'd0, p.mb};
		q = num / {32'd0, sq[63:0]};
		f = (q[95:32] != 0) ? 32'hFFFFFFFF : q[31:0];
		if (f <= {16'd0, eps}) return r;
		r.fx = axis_force(f, dx, d);
		r.fy = axis_force(f, dy, d);
		r.applied = 1'b1;
		return r;
	endfunction

	function automatic pair_row_t current_pair();
		pair_row_t p;
		p = '0;
		p.ax = pos_a_x; p.ay = pos_a_y; p.bx = pos_b_x; p.by = pos_b_y;
		p.ma = mass_a; p.mb = mass_b; p.inf_a = infinite_a; p.inf_b = infinite_b;
		return p;
	endfunction

	// Scoreboard: predict on each pair transfer, compare on each done strobe.
	// Inputs are driven by NBA, so values seen here are the ones the edge takes.
	always @(posedge clk) begin
		force_t exp_f;
		if (arst_n) begin
			if (start && !busy) pending_forces.push_back(gravity_on_a(current_pair()));
			if (done) begin
				if (pending_forces.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) $display("unexpected result at %0t", $realtime);
				end else begin
					exp_f = pending_forces.pop_front();
					if (exp_f.fx !== force_x || exp_f.fy !== force_y ||
							exp_f.applied !== force_applied) begin
						mismatches++;
						if (mismatches <= 10)
							$display("force mismatch: exp (%0d,%0d,%b) got (%0d,%0d,%b)",
								exp_f.fx, exp_f.fy, exp_f.applied,
								force_x, force_y, force_applied);
					end
				end
			end
			if (wr_en) begin
				case (wr_index)
					REG_GRAVITY: g_const <= wr_data;
					REG_CUTOFF:  cutoff <= wr_data;
					REG_EPSILON: eps <= wr_data[EPS_W-1:0];
					default: ;
				endcase
			end
			// watchdog: any transfer in or out resets it
			if ((start && !busy) || done) stall_cycles <= 0;
			else stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	// mostly back-to-back or short gaps, now and then a long one
	function automatic int unsigned gap_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (burst_mode || r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// offer one pair, hold it until taken, then maybe drop start for a while
	task automatic send_pair(pair_row_t p);
		int unsigned gap;
		start <= 1'b1;
		pos_a_x <= p.ax; pos_a_y <= p.ay; pos_b_x <= p.bx; pos_b_y <= p.by;
		mass_a <= p.ma; mass_b <= p.mb; infinite_a <= p.inf_a; infinite_b <= p.inf_b;
		do @(negedge clk); while (busy);
		@(posedge clk);
		gap = gap_len();
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// leaves wr_en high; the caller drops it after the last write of a burst
	task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= val;
		@(posedge clk);
	endtask

	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (pending_forces.size() != 0) @(posedge clk);
	endtask

	function automatic logic [31:0] rand_scaled();
		return $urandom >> $urandom_range(0, 31);
	endfunction

	function automatic pair_row_t rand_pair();
		pair_row_t p;
		logic [31:0] ddx, ddy;
		p = '0;
		if ($urandom_range(0, 9) < 7) begin
			// bodies near each other, so most pairs reach the divide
			p.ax = $urandom; p.ay = $urandom;
			ddx = rand_scaled() >> 6;
			ddy = rand_scaled() >> 6;
			p.bx = p.ax + ($urandom_range(0, 1) ? -ddx : ddx);
			p.by = p.ay + ($urandom_range(0, 1) ? -ddy : ddy);
			p.ma = rand_scaled(); p.mb = rand_scaled();
			p.inf_a = ($urandom_range(0, 7) == 0);
			p.inf_b = ($urandom_range(0, 7) == 0);
		end else begin
			p.ax = $urandom; p.ay = $urandom; p.bx = $urandom; p.by = $urandom;
			p.ma = $urandom; p.mb = $urandom;
			p.inf_a = ($urandom_range(0, 1) == 1);
			p.inf_b = ($urandom_range(0, 1) == 1);
		end
		return p;
	endfunction

	pair_row_t directed[] = '{
		// unit masses one unit apart under reset G: force 1.0 along +x
		'{32'd0, 32'd0, 32'h10000, 32'd0, 32'h10000, 32'h10000, 1'b0, 1'b0,
			1'b1, '{32'h10000, 32'd0, 1'b1}},
		// both bodies infinite
		'{32'd0, 32'd0, 32'h10000, 32'd0, 32'h10000, 32'h10000, 1'b1, 1'b1,
			1'b1, '{32'd0, 32'd0, 1'b0}},
		// coincident bodies
		'{32'h12345, 32'hFFFF0000, 32'h12345, 32'hFFFF0000, 32'h10000, 32'h10000,
			1'b0, 1'b0, 1'b1, '{32'd0, 32'd0, 1'b0}},
		// square sum beyond 64 bits
		'{32'h80000000, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'hFFFFFFFF,
			32'hFFFFFFFF, 1'b0, 1'b0, 1'b1, '{32'd0, 32'd0, 1'b0}},
		// opposite extremes on one axis only
		'{32'h80000000, 32'd0, 32'h7FFFFFFF, 32'd0, 32'hFFFFFFFF, 32'hFFFFFFFF,
			1'b0, 1'b0, 1'b0, '0},
		// zero mass: negligible force
		'{32'd0, 32'd0, 32'h10000, 32'd0, 32'd0, 32'h10000, 1'b0, 1'b0,
			1'b1, '{32'd0, 32'd0, 1'b0}},
		// one lsb apart: within epsilon
		'{32'd0, 32'd0, 32'd1, 32'd0, 32'h10000, 32'h10000, 1'b0, 1'b0,
			1'b1, '{32'd0, 32'd0, 1'b0}},
		// two lsb apart, heavy: saturates
		'{32'd0, 32'd0, 32'd2, 32'd0, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b0, 1'b0,
			1'b0, '0},
		'{32'd5, 32'd7, 32'd3, 32'd5, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b0, 1'b0,
			1'b0, '0},
		// exactly at the cutoff, and one lsb past it
		'{32'd0, 32'd0, 32'd0, 32'd6553600, 32'h10000, 32'h10000, 1'b0, 1'b0,
			1'b0, '0},
		'{32'd0, 32'd0, 32'd0, 32'd6553601, 32'h10000, 32'h10000, 1'b0, 1'b0,
			1'b1, '{32'd0, 32'd0, 1'b0}},
		// one infinite body keeps its given mass
		'{32'h30000, 32'h40000, 32'd0, 32'd0, 32'h20000, 32'h8000, 1'b1, 1'b0,
			1'b0, '0},
		'{32'h30000, 32'h40000, 32'd0, 32'd0, 32'h20000, 32'h8000, 1'b0, 1'b1,
			1'b0, '0},
		// negative directions, diagonal
		'{32'h10000, 32'h10000, 32'hFFFF8000, 32'hFFFE0000, 32'h50000, 32'h30000,
			1'b0, 1'b0, 1'b0, '0},
		'{32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFF0000, 32'h7FFE0000, 32'hFFFFFFFF,
			32'd1, 1'b0, 1'b0, 1'b0, '0}
	};

	initial begin
		force_t got;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed rows under reset registers
		foreach (directed[i]) begin
			if (directed[i].known) begin
				got = gravity_on_a(directed[i]);
				if (got !== directed[i].want) begin
					mismatches++;
					if (mismatches <= 10) $display("predictor disagrees on row %0d", i);
				end
			end
			send_pair(directed[i]);
		end
		drain();

		// register settings: extremes, then random ones; the spare slot is poked too
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: begin
					write_reg(REG_GRAVITY, 32'hFFFFFFFF);
					write_reg(REG_CUTOFF, 32'hFFFFFFFF);
					write_reg(REG_EPSILON, 32'hFFFF0000);
				end
				1: begin
					write_reg(REG_GRAVITY, 32'd0);
					write_reg(REG_SPARE, $urandom);
				end
				2: begin
					write_reg(REG_GRAVITY, 32'h10000);
					write_reg(REG_CUTOFF, 32'd0);
					write_reg(REG_EPSILON, 32'hFFFF);
				end
				default: begin
					write_reg(REG_GRAVITY, rand_scaled());
					write_reg(REG_CUTOFF, rand_scaled());
					write_reg(REG_EPSILON, $urandom & (ph == 5 ? 32'hFFFF : 32'hFF));
				end
			endcase
			wr_en <= 1'b0;
			for (int n = 0; n < 85; n++) begin
				if (n % 30 == 0) burst_mode = ($urandom_range(0, 2) == 0);
				send_pair(rand_pair());
			end
			burst_mode = 1'b0;
			drain();
		end

		repeat (LATENCY + 8) @(posedge clk);
		if (mismatches == 0 && pending_forces.size() == 0 && !done) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

/* filelist.f */
rtl/core/pgf_pkg.sv
rtl/core/pgf_sqrt_cell.sv
rtl/core/pgf_div_cell.sv
rtl/core/pairwise_gravity_force.sv
verif/tb_pairwise_gravity_force.sv
